// ----- design/cassette_tone_qualifier_bit_recovery_assert.svh -----
// Assertion macros used by the cassette tone qualifier top level.
`ifndef CASSETTE_TONE_QUALIFIER_BIT_RECOVERY_ASSERT_SVH
`define CASSETTE_TONE_QUALIFIER_BIT_RECOVERY_ASSERT_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define CTQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check that cons holds in the cycle after ante holds.
`define CTQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/ctq_pkg.sv -----
// Types and constants for the cassette tone qualifier and bit recovery block.
`timescale 1ns / 1ps

package ctq_pkg;

    typedef enum logic [1:0] {
        TONE_ZERO    = 2'd0,
        TONE_ONE     = 2'd1,
        TONE_LEADER  = 2'd2,
        TONE_SILENCE = 2'd3
    } t_tone;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_BAUD_MODE        = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STRIP_ENABLE     = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PHANTOM_PROTECT  = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEADER_THRESHOLD = 8'd3;

    localparam int SLOW_TONES_DEFAULT = 4;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 32;
    localparam int STAMP_W    = 24;
    localparam int WAIT_W     = 16;
    localparam int SKIP_W     = 4;
    localparam int SINCE_W    = 7;
    localparam int HOLDOFF_W  = 10;

    localparam logic [SKIP_W-1:0]    SKIP_LIMIT    = 4'd10;
    localparam logic [SINCE_W-1:0]   GUARD_TONES   = 7'd100;
    localparam logic [HOLDOFF_W-1:0] STRIP_HOLDOFF = 10'd800;
    localparam logic [WAIT_W-1:0]    WAIT_MAX      = '1;
    localparam logic [STAMP_W-1:0]   ELAPSED_MAX   = '1;
    localparam logic [WAIT_W-1:0]    THRESHOLD_RESET = 16'd600;

    typedef struct packed {
        logic                  last;
        logic                  user;
        logic [OUT_DATA_W-1:0] data;
    } t_result;

endpackage

// ----- design/cassette_tone_qualifier_bit_recovery.sv -----
// Top level of the cassette tone qualifier and bit recovery block.
`timescale 1ns / 1ps

// Cassette tone qualifier and bit recovery. Each input transfer carries one
// 1/1200 s tape tone; each one yields exactly one output transfer, in order.
// The block takes one tone per clock cycle while s_axis_tready is high: all
// qualification, the slow-mode bit assembly and the elapsed tally are one
// pass of logic from the state registers into a two-deep output register
// (main stage plus skid stage), so a tone is accepted even while one
// finished result is still waiting for downstream to take it. s_axis_tready
// drops only while both output stages hold results. Configuration writes
// are taken at any time (o_cfg_ready is always high) but must only be
// issued while no result is outstanding. Output tuser is bit_valid: when it
// is low bit_code is zero and no bit goes to the serial receiver.
module cassette_tone_qualifier_bit_recovery #(
    parameter int SLOW_TONES = ctq_pkg::SLOW_TONES_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ctq_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [ctq_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // tone input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [1:0] tone_code, [2] awaiting_start, [26:3] stamp_value, [31:27] zero
    input  logic [ctq_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // [0] stamp_valid
    input  logic                             s_axis_tuser,
    // end_of_tape
    input  logic                             s_axis_tlast,
    // bit output stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [1:0] bit_code, [3:2] prevailing_tone, [27:4] elapsed_tally, [31:28] zero
    output logic [ctq_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // [0] bit_valid
    output logic                             m_axis_tuser,
    // eof_seen
    output logic                             m_axis_tlast
);

    localparam int FILL_W = (SLOW_TONES > 1) ? $clog2(SLOW_TONES) : 1;
    localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(SLOW_TONES - 1);

    // configuration registers
    logic                           r_baud_mode;
    logic                           r_strip_enable;
    logic                           r_phantom_enable;
    logic [ctq_pkg::WAIT_W-1:0]     r_threshold;

    // qualifier state
    logic [ctq_pkg::SKIP_W-1:0]     r_leader_skip,  n_leader_skip;
    logic [ctq_pkg::WAIT_W-1:0]     r_start_wait,   n_start_wait;
    logic [ctq_pkg::SINCE_W-1:0]    r_since_silence, n_since_silence;
    logic [ctq_pkg::HOLDOFF_W-1:0]  r_holdoff,      n_holdoff;
    ctq_pkg::t_tone                 r_slow_head,    n_slow_head;
    logic [FILL_W-1:0]              r_slow_fill,    n_slow_fill;
    logic [ctq_pkg::STAMP_W-1:0]    r_elapsed,      n_elapsed;
    ctq_pkg::t_tone                 r_prevailing,   n_prevailing;

    // output stages
    logic                           r_out_valid;
    ctq_pkg::t_result               r_out;
    logic                           r_skid_valid;
    ctq_pkg::t_result               r_skid;
    ctq_pkg::t_result               n_result;

    logic in_fire;
    logic out_fire;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_skid_valid;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = r_out_valid && m_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.data;
    assign m_axis_tuser  = r_out.user;
    assign m_axis_tlast  = r_out.last;

    // Qualify one tone and work out the next state and the result.
    always_comb begin
        ctq_pkg::t_tone         v_tone;
        ctq_pkg::t_tone         v_bit;
        ctq_pkg::t_tone         v_head_norm;
        ctq_pkg::t_tone         v_tone_norm;
        logic                   v_eot;
        logic                   v_waiting;
        logic                   v_strip;
        logic                   v_guard;
        logic                   v_kept;
        logic                   v_bit_valid;

        v_tone      = ctq_pkg::t_tone'(s_axis_tdata[1:0]);
        v_eot       = s_axis_tlast;
        v_waiting   = s_axis_tdata[2];
        v_guard     = 1'b0;
        v_kept      = 1'b1;
        v_bit_valid = 1'b0;
        v_bit       = ctq_pkg::TONE_ZERO;
        v_head_norm = ctq_pkg::TONE_ZERO;
        v_tone_norm = ctq_pkg::TONE_ZERO;

        n_leader_skip   = r_leader_skip;
        n_start_wait    = r_start_wait;
        n_since_silence = r_since_silence;
        n_holdoff       = r_holdoff;
        n_slow_head     = r_slow_head;
        n_slow_fill     = r_slow_fill;
        n_elapsed       = r_elapsed;
        n_prevailing    = r_prevailing;

        // Stripping waits out the holdoff in fast mode only.
        if (r_baud_mode) begin
            v_strip = r_strip_enable;
        end else begin
            v_strip = r_strip_enable && (r_holdoff >= ctq_pkg::STRIP_HOLDOFF);
        end
        if (r_holdoff < ctq_pkg::STRIP_HOLDOFF) begin
            n_holdoff = r_holdoff + 1'b1;
        end

        if (v_eot) begin
            // End of tape: report silence and skip the other qualification rules.
            n_leader_skip = '0;
            v_tone        = ctq_pkg::TONE_SILENCE;
        end else begin
            // Turn the first few leader tones of a run back into ones.
            if (v_tone == ctq_pkg::TONE_ZERO || v_tone == ctq_pkg::TONE_SILENCE) begin
                n_leader_skip = '0;
            end else if (v_tone == ctq_pkg::TONE_LEADER &&
                         r_leader_skip < ctq_pkg::SKIP_LIMIT) begin
                n_leader_skip = r_leader_skip + 1'b1;
                v_tone        = ctq_pkg::TONE_ONE;
            end

            if (v_waiting) begin
                // A long start-bit wait on ones means leader.
                if (r_start_wait > r_threshold && v_tone == ctq_pkg::TONE_ONE) begin
                    v_tone = ctq_pkg::TONE_LEADER;
                end
                if (!v_strip) begin
                    if (v_tone == ctq_pkg::TONE_SILENCE) begin
                        n_since_silence = '0;
                    end else if (r_since_silence < ctq_pkg::GUARD_TONES) begin
                        n_since_silence = r_since_silence + 1'b1;
                        v_guard         = 1'b1;
                    end
                end
                if (r_start_wait != ctq_pkg::WAIT_MAX) begin
                    n_start_wait = r_start_wait + 1'b1;
                end
            end else begin
                n_start_wait = '0;
            end
            if (v_tone == ctq_pkg::TONE_ZERO || v_tone == ctq_pkg::TONE_SILENCE) begin
                n_start_wait = '0;
            end

            if (v_strip && (v_tone == ctq_pkg::TONE_LEADER ||
                            v_tone == ctq_pkg::TONE_SILENCE)) begin
                v_kept = 1'b0;
            end else if (v_guard && r_phantom_enable) begin
                // Hold off start bits for a while after silence.
                v_tone = ctq_pkg::TONE_LEADER;
            end

            // Advance the tally, or load it from an exact stamp.
            if (s_axis_tuser) begin
                n_elapsed = s_axis_tdata[26:3];
            end else if (r_elapsed != ctq_pkg::ELAPSED_MAX) begin
                n_elapsed = r_elapsed + 1'b1;
            end
        end

        if (!r_baud_mode) begin
            n_slow_fill = '0;
            if (v_kept) begin
                n_prevailing = v_tone;
                v_bit_valid  = 1'b1;
                v_bit        = v_tone;
            end
        end else if (v_kept) begin
            // Slow mode: collect matching tones, leader counts as one.
            n_prevailing = v_tone;
            if (r_slow_fill == '0) begin
                n_slow_head = v_tone;
            end
            v_head_norm = (n_slow_head == ctq_pkg::TONE_LEADER) ? ctq_pkg::TONE_ONE
                                                                : n_slow_head;
            v_tone_norm = (v_tone == ctq_pkg::TONE_LEADER) ? ctq_pkg::TONE_ONE : v_tone;
            if (v_head_norm != v_tone_norm) begin
                n_slow_head = v_tone;
                n_slow_fill = FILL_W'(1);
            end else if (r_slow_fill == FILL_LAST) begin
                v_bit_valid = 1'b1;
                v_bit       = n_slow_head;
                n_slow_fill = '0;
            end else begin
                n_slow_fill = r_slow_fill + 1'b1;
            end
        end

        n_result.last = v_eot;
        n_result.user = v_bit_valid;
        n_result.data = {4'b0000, n_elapsed, n_prevailing, v_bit};
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_baud_mode      <= 1'b0;
            r_strip_enable   <= 1'b0;
            r_phantom_enable <= 1'b1;
            r_threshold      <= ctq_pkg::THRESHOLD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                ctq_pkg::CFG_BAUD_MODE:        r_baud_mode      <= i_cfg_data[0];
                ctq_pkg::CFG_STRIP_ENABLE:     r_strip_enable   <= i_cfg_data[0];
                ctq_pkg::CFG_PHANTOM_PROTECT:  r_phantom_enable <= i_cfg_data[0];
                ctq_pkg::CFG_LEADER_THRESHOLD: r_threshold      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Commit the state on every input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leader_skip   <= '0;
            r_start_wait    <= '0;
            r_since_silence <= '0;
            r_holdoff       <= '0;
            r_slow_head     <= ctq_pkg::TONE_ZERO;
            r_slow_fill     <= '0;
            r_elapsed       <= '0;
            r_prevailing    <= ctq_pkg::TONE_ONE;
        end else if (in_fire) begin
            r_leader_skip   <= n_leader_skip;
            r_start_wait    <= n_start_wait;
            r_since_silence <= n_since_silence;
            r_holdoff       <= n_holdoff;
            r_slow_head     <= n_slow_head;
            r_slow_fill     <= n_slow_fill;
            r_elapsed       <= n_elapsed;
            r_prevailing    <= n_prevailing;
        end
    end

    // Output register with skid stage: park a result in the skid stage
    // when the main stage is stalled, drain it first once downstream moves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_skid_valid <= 1'b0;
            end
        end else if (in_fire) begin
            if (r_out_valid && !m_axis_tready) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_out <= r_skid;
            end
        end else if (in_fire) begin
            if (r_out_valid && !m_axis_tready) begin
                r_skid <= n_result;
            end else begin
                r_out <= n_result;
            end
        end
    end

`include "cassette_tone_qualifier_bit_recovery_assert.svh"

    `CTQ_ASSERT_SAME(a_skid_behind_out, r_skid_valid, r_out_valid, "skid full with main stage empty")
    `CTQ_ASSERT_SAME(a_fill_range, 1'b1, r_slow_fill <= FILL_LAST, "slow fill out of range")
    `CTQ_ASSERT_SAME(a_skip_range, 1'b1, r_leader_skip <= ctq_pkg::SKIP_LIMIT, "leader skip out of range")
    `CTQ_ASSERT_NEXT(a_fast_fill_clear, in_fire && !r_baud_mode, r_slow_fill == '0, "fast mode kept slow fill")
    `CTQ_ASSERT_NEXT(a_eot_tally_hold, in_fire && s_axis_tlast, $stable(r_elapsed), "tally moved at end of tape")

endmodule
